// ===== rtl/stcr_pkg.sv =====
package stcr_pkg;

  localparam int TEXT_ROWS_DEF    = 22;
  localparam int TEXT_COLUMNS_DEF = 51;

  localparam int FRAME_W = 10;
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 10'd320;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 10'd240;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // Text origin and pitch in pixels.
  localparam logic [9:0] TEXT_Y0 = 10'd20;
  localparam logic [9:0] TEXT_X0 = 10'd4;
  localparam logic [9:0] ROW_PITCH = 10'd10;
  localparam logic [9:0] COL_PITCH = 10'd6;
  localparam logic [9:0] GLYPH_W = 10'd5;
  localparam logic [9:0] GLYPH_H = 10'd7;

  // Reciprocal multipliers, exact for all 10-bit dividends.
  localparam logic [17:0] DIV10_MUL = 18'd205;
  localparam int          DIV10_SH  = 11;
  localparam logic [19:0] DIV6_MUL  = 20'd683;
  localparam int          DIV6_SH   = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_QDIV,
    ST_QADDR,
    ST_QFONT
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] width;
    logic [FRAME_W-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    logic vld;
    logic lit;
  } result_t;

  // Glyph rows, top row in the highest five bits, glyph bit 4 is the left dot.
  function automatic logic [34:0] font_glyph(input logic [7:0] b);
    logic [7:0]  c;
    logic [34:0] g;
    c = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      c = b - 8'h20;
    end
    unique case (c)
      8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'h31: g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h32: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      8'h33: g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h34: g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      8'h36: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'h37: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h42: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'h43: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      8'h44: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'h46: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h47: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h49: g = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h4A: g = {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
      8'h4B: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      8'h4C: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'h4D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'h4E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'h4F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h51: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h54: g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h55: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      8'h57: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      8'h58: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      8'h59: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h5A: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      8'h2D: g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      8'h2B: g = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
      8'h3A: g = {5'd0, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4, 5'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] font_row(input logic [7:0] b, input logic [2:0] dy);
    logic [34:0] g;
    logic [4:0]  r;
    g = font_glyph(b);
    unique case (dy)
      3'd0: r = g[34:30];
      3'd1: r = g[29:25];
      3'd2: r = g[24:20];
      3'd3: r = g[19:15];
      3'd4: r = g[14:10];
      3'd5: r = g[9:5];
      3'd6: r = g[4:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/stcr_ram.sv =====
module stcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/stcr_seq.sv =====
module stcr_seq #(
  parameter int TEXT_ROWS    = stcr_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = stcr_pkg::TEXT_COLUMNS_DEF,
  localparam int RW = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1,
  localparam int CW = $clog2(TEXT_COLUMNS + 1),
  localparam int DEPTH = TEXT_ROWS * TEXT_COLUMNS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  op,
  input  logic [7:0]            char_byte,
  input  logic [9:0]            pixel_x,
  input  logic [9:0]            pixel_y,
  input  stcr_pkg::frame_cfg_t  frame_cfg,
  input  logic                  out_free,
  output stcr_pkg::result_t     res,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [7:0]            ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  input  logic [7:0]            ram_rdata
);

  localparam logic [RW-1:0] ROW_LAST = RW'(TEXT_ROWS - 1);
  localparam logic [RW:0]   ROWS_W   = (RW + 1)'(TEXT_ROWS);
  localparam logic [CW-1:0] COLS_C   = CW'(TEXT_COLUMNS);
  localparam logic [6:0]    ROWS_Q   = 7'(TEXT_ROWS);

  function automatic logic [RW-1:0] wrap_add(input logic [RW-1:0] a, input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ROWS_W) begin
      s = s - ROWS_W;
    end
    return s[RW-1:0];
  endfunction

  stcr_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [CW-1:0] len_r [TEXT_ROWS];
  logic [CW-1:0] len_nxt [TEXT_ROWS];

  logic [7:0] byte_r;
  logic [9:0] px_r, py_r;
  logic [6:0] qi_r, qi_nxt;
  logic [7:0] qk_r, qk_nxt;
  logic [2:0] dy_r, dy_nxt;
  logic [2:0] dx_r, dx_nxt;
  logic       hit_r, hit_nxt;

  logic          accept;
  logic          wr_active;
  logic [AW-1:0] wr_addr;
  logic          q_lit;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stcr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (op == stcr_pkg::OP_QUERY) ? stcr_pkg::ST_QDIV : stcr_pkg::ST_WRITE;
        end
      end
      stcr_pkg::ST_WRITE: state_nxt = stcr_pkg::ST_IDLE;
      stcr_pkg::ST_QDIV:  state_nxt = stcr_pkg::ST_QADDR;
      stcr_pkg::ST_QADDR: state_nxt = stcr_pkg::ST_QFONT;
      stcr_pkg::ST_QFONT: begin
        if (out_free) begin
          state_nxt = stcr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res.vld   = 1'b0;
    res.lit   = q_lit;
    unique case (state_r)
      stcr_pkg::ST_IDLE:  in_tready = 1'b1;
      stcr_pkg::ST_WRITE: ram_we = wr_active;
      stcr_pkg::ST_QDIV:  ram_re = 1'b0;
      stcr_pkg::ST_QADDR: ram_re = 1'b1;
      stcr_pkg::ST_QFONT: res.vld = out_free;
      default: in_tready = 1'b0;
    endcase
  end

  // Character write: new row handling, store write and visible length update.
  logic          is_cr, is_lf, new_line, row_last;
  logic [RW-1:0] nrow, ntop, wphys;
  logic [CW-1:0] ncol, eff_len;

  always_comb begin
    is_cr    = byte_r == stcr_pkg::CHAR_CR;
    is_lf    = byte_r == stcr_pkg::CHAR_LF;
    new_line = is_lf || (cur_col_r >= COLS_C);
    row_last = cur_row_r == ROW_LAST;
    nrow     = cur_row_r;
    ntop     = top_r;
    ncol     = cur_col_r;
    if (new_line) begin
      ncol = '0;
      if (row_last) begin
        ntop = wrap_add(top_r, RW'(1));
      end else begin
        nrow = cur_row_r + RW'(1);
      end
    end
    wphys   = wrap_add(ntop, nrow);
    eff_len = new_line ? '0 : len_r[wphys];
    wr_active = !is_cr && !is_lf;
    wr_addr = AW'(wphys) * AW'(TEXT_COLUMNS) + AW'(ncol);

    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    top_nxt     = top_r;
    len_nxt     = len_r;
    if (state_r == stcr_pkg::ST_WRITE && !is_cr) begin
      cur_row_nxt = nrow;
      top_nxt     = ntop;
      cur_col_nxt = ncol;
      if (new_line) begin
        len_nxt[wphys] = '0;
      end
      if (!is_lf) begin
        cur_col_nxt = ncol + CW'(1);
        if (byte_r != stcr_pkg::CHAR_NUL && eff_len == ncol) begin
          len_nxt[wphys] = ncol + CW'(1);
        end
      end
    end
  end

  assign ram_waddr = wr_addr;
  assign ram_wdata = byte_r;

  // Pixel query: divide by the pitches, then range checks and store address.
  logic [9:0]    nx, ny;
  logic [17:0]   prod10;
  logic [19:0]   prod6;
  logic [9:0]    dy_full, dx_full;
  logic [RW-1:0] qphys;
  logic [CW-1:0] qlen;
  logic [10:0]   xend;
  logic [4:0]    glyph_row;

  always_comb begin
    ny      = py_r - stcr_pkg::TEXT_Y0;
    nx      = px_r - stcr_pkg::TEXT_X0;
    prod10  = {8'b0, ny} * stcr_pkg::DIV10_MUL;
    prod6   = {10'b0, nx} * stcr_pkg::DIV6_MUL;
    qi_nxt  = prod10[stcr_pkg::DIV10_SH +: 7];
    qk_nxt  = prod6[stcr_pkg::DIV6_SH +: 8];

    dy_full = ny - {3'b0, qi_r} * stcr_pkg::ROW_PITCH;
    dx_full = nx - {2'b0, qk_r} * stcr_pkg::COL_PITCH;
    dy_nxt  = dy_full[2:0];
    dx_nxt  = dx_full[2:0];
    qphys   = wrap_add(top_r, qi_r[RW-1:0]);
    qlen    = len_r[qphys];
    xend    = {3'b0, qk_r} * 11'd6 + 11'd9;
    hit_nxt = (py_r >= stcr_pkg::TEXT_Y0) && (px_r >= stcr_pkg::TEXT_X0)
           && (py_r < frame_cfg.height) && (qi_r < ROWS_Q)
           && (dy_full < stcr_pkg::GLYPH_H) && (dx_full < stcr_pkg::GLYPH_W)
           && ({1'b0, qk_r} < 9'(qlen)) && (xend <= {1'b0, frame_cfg.width});
    ram_raddr = AW'(qphys) * AW'(TEXT_COLUMNS) + AW'(qk_r);

    glyph_row = stcr_pkg::font_row(ram_rdata, dy_r);
    q_lit     = hit_r && |(glyph_row & (5'b10000 >> dx_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= stcr_pkg::ST_IDLE;
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
      for (int r = 0; r < TEXT_ROWS; r++) begin
        len_r[r] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      top_r     <= top_nxt;
      len_r     <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= char_byte;
      px_r   <= pixel_x;
      py_r   <= pixel_y;
    end
    if (state_r == stcr_pkg::ST_QDIV) begin
      qi_r <= qi_nxt;
      qk_r <= qk_nxt;
    end
    if (state_r == stcr_pkg::ST_QADDR) begin
      dy_r  <= dy_nxt;
      dx_r  <= dx_nxt;
      hit_r <= hit_nxt;
    end
  end

endmodule

// ===== rtl/scrolling_text_console_renderer.sv =====
// Text console of TEXT_ROWS rows by TEXT_COLUMNS characters drawn in a 5x7 font.
// A word with tuser 0 writes the byte in tdata[7:0]; a word with tuser 1 asks
// whether pixel (tdata[17:8], tdata[27:18]) is lit and returns one word whose
// bit 0 is the answer. The block handles one word at a time: a character write
// is stored in a single write state, and a pixel query steps through divide,
// range check and store read, then font lookup, which waits until the output
// register is free; the store read uses the single read port of the character
// memory. A finished result waits in an output register, and the next word is
// taken while it waits. The character memory needs no clearing after reset.
// frame_width and frame_height may only be written while no word is in flight.
module scrolling_text_console_renderer #(
  parameter int TEXT_ROWS    = stcr_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = stcr_pkg::TEXT_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,  // char_byte, pixel_x, pixel_y
  input  logic                           in_tuser,  // op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // pixel_lit
  input  logic                           cfg_we,
  input  logic [stcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stcr_pkg::FRAME_W-1:0]   cfg_wdata
);

  localparam int DEPTH = TEXT_ROWS * TEXT_COLUMNS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  stcr_pkg::frame_cfg_t cfg_r, cfg_nxt;
  stcr_pkg::result_t    res;

  logic          out_valid_r, out_valid_nxt;
  logic          out_lit_r;
  logic          out_free;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        stcr_pkg::CFG_FRAME_WIDTH:  cfg_nxt.width  = cfg_wdata;
        stcr_pkg::CFG_FRAME_HEIGHT: cfg_nxt.height = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= stcr_pkg::FRAME_WIDTH_RST;
      cfg_r.height <= stcr_pkg::FRAME_HEIGHT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_lit_r <= res.lit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_lit_r};

  stcr_seq #(
    .TEXT_ROWS    (TEXT_ROWS),
    .TEXT_COLUMNS (TEXT_COLUMNS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (in_tuser),
    .char_byte (in_tdata[7:0]),
    .pixel_x   (in_tdata[17:8]),
    .pixel_y   (in_tdata[27:18]),
    .frame_cfg (cfg_r),
    .out_free  (out_free),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  stcr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/stcr_chk.sv =====
module stcr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // One word is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in flight");

  // A character write never produces a result word.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == stcr_pkg::OP_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("result word after a character write");

  // A query into an empty output register answers after the divide, address and font states.
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == stcr_pkg::OP_QUERY && !out_tvalid
    |-> ##4 out_tvalid)
    else $error("pixel query result missing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

endmodule

bind scrolling_text_console_renderer stcr_chk u_chk (.*);
